FILE: design/hgp_pkg.sv
// hgp_pkg: shared types, constants and azimuth cosine tables for the
// henyey-greenstein phase evaluation unit; no dependencies
package hgp_pkg;

  localparam int COS_TABLE_BITS = 10;
  localparam int AZ_SHIFT       = 16 - COS_TABLE_BITS;
  localparam int QUARTER_N      = 1 << (COS_TABLE_BITS - 2);

  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 32;
  // start edge to result strobe
  localparam int LATENCY = 2 + SQRT_STAGES + 4 + SQRT_STAGES + 2 + 1 + DIV_STAGES + 1;

  localparam logic [63:0] PI_Q30     = 64'd3373259426;
  localparam logic [28:0] INV4PI_Q32 = 29'd341782638;
  localparam logic signed [15:0] G_MINUS_ONE = 16'sh8000;

  typedef struct packed {
    logic signed [15:0] cos_out;
    logic signed [15:0] cos_in;
    logic [15:0]        azimuth_diff;
  } hgp_in_t;

  typedef struct packed {
    logic [31:0] density;
    logic        saturated;
  } hgp_out_t;

  typedef logic [30:0] tab_t [QUARTER_N];

  function automatic logic [63:0] to_rad(input logic [63:0] r);
    return (r * PI_Q30) >> 15;
  endfunction

  function automatic logic [63:0] poly_cos(input logic [63:0] t);
    logic [63:0] one;
    logic [63:0] t2;
    logic [63:0] h;
    one = 64'd1 << 30;
    t2  = (t * t) >> 30;
    h   = one - t2 / 56;
    h   = one - ((t2 * h) >> 30) / 30;
    h   = one - ((t2 * h) >> 30) / 12;
    return one - ((t2 * h) >> 30) / 2;
  endfunction

  function automatic logic [63:0] poly_sin(input logic [63:0] t);
    logic [63:0] one;
    logic [63:0] t2;
    logic [63:0] h;
    one = 64'd1 << 30;
    t2  = (t * t) >> 30;
    h   = one - t2 / 72;
    h   = one - ((t2 * h) >> 30) / 42;
    h   = one - ((t2 * h) >> 30) / 20;
    h   = one - ((t2 * h) >> 30) / 6;
    return (t * h) >> 30;
  endfunction

  // cosine of the in-quadrant angle, octant folded
  function automatic tab_t build_cos();
    tab_t tb;
    logic [63:0] r;
    for (int j = 0; j < QUARTER_N; j++) begin
      r = 64'(j) << AZ_SHIFT;
      if (r <= 64'd8192) begin
        tb[j] = 31'(poly_cos(to_rad(r)));
      end else begin
        tb[j] = 31'(poly_sin(to_rad(64'd16384 - r)));
      end
    end
    return tb;
  endfunction

  // sine of the in-quadrant angle, octant folded
  function automatic tab_t build_sin();
    tab_t tb;
    logic [63:0] r;
    for (int j = 0; j < QUARTER_N; j++) begin
      r = 64'(j) << AZ_SHIFT;
      if (r <= 64'd8192) begin
        tb[j] = 31'(poly_sin(to_rad(r)));
      end else begin
        tb[j] = 31'(poly_cos(to_rad(64'd16384 - r)));
      end
    end
    return tb;
  endfunction

  localparam tab_t COS_TAB = build_cos();
  localparam tab_t SIN_TAB = build_sin();

endpackage

FILE: design/hgp_isqrt.sv
// hgp_isqrt: pipelined floor square root of a 64-bit value, one root bit per stage
// depends on hgp_pkg for the stage count
module hgp_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [63:0] radicand_i,
  output logic        valid_o,
  output logic [31:0] root_o
);

  localparam int NS = hgp_pkg::SQRT_STAGES;

  logic [63:0]   rem_q  [NS];
  logic [63:0]   root_q [NS];
  logic [NS-1:0] vld_q;

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [63:0] rem_in;
    logic [63:0] root_in;
    logic        vld_in;
    logic [63:0] bit_c;
    logic [63:0] trial;
    logic [63:0] rem_d;
    logic [63:0] root_d;

    if (s == 0) begin : g_first
      assign rem_in  = radicand_i;
      assign root_in = '0;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    assign bit_c = 64'd1 << (62 - 2 * s);
    assign trial = root_in + bit_c;

    always_comb begin
      if (rem_in >= trial) begin
        rem_d  = rem_in - trial;
        root_d = (root_in >> 1) + bit_c;
      end else begin
        rem_d  = rem_in;
        root_d = root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s]  <= rem_d;
      root_q[s] <= root_d;
    end
  end

  assign valid_o = vld_q[NS-1];
  assign root_o  = root_q[NS-1][31:0];

endmodule

FILE: design/hgp_div.sv
// hgp_div: pipelined restoring divider, 32 quotient bits with overflow flag
// depends on hgp_pkg for the stage count
module hgp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [60:0] dividend_i,
  input  logic [45:0] divisor_i,
  output logic        valid_o,
  output logic [31:0] quot_o,
  output logic        sat_o
);

  localparam int NS = hgp_pkg::DIV_STAGES;

  logic [45:0] rem_q [NS+1];
  logic [31:0] lo_q  [NS+1];
  logic [45:0] dvs_q [NS+1];
  logic [31:0] quo_q [NS+1];
  logic [NS:0] sat_q;
  logic [NS:0] vld_q;

  // quotient above 32 bits, or zero divisor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= {17'b0, dividend_i[60:32]};
    lo_q[0]  <= dividend_i[31:0];
    dvs_q[0] <= divisor_i;
    quo_q[0] <= '0;
    sat_q[0] <= ({17'b0, dividend_i[60:32]} >= divisor_i);
  end

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [46:0] part;
    logic        take;
    logic [46:0] diff;

    assign part = {rem_q[s], lo_q[s][31]};
    assign take = (part >= {1'b0, dvs_q[s]});
    assign diff = part - {1'b0, dvs_q[s]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= take ? diff[45:0] : part[45:0];
      lo_q[s+1]  <= {lo_q[s][30:0], 1'b0};
      dvs_q[s+1] <= dvs_q[s];
      quo_q[s+1] <= {quo_q[s][30:0], take};
      sat_q[s+1] <= sat_q[s];
    end
  end

  assign valid_o = vld_q[NS];
  assign quot_o  = quo_q[NS];
  assign sat_o   = sat_q[NS];

endmodule

FILE: design/henyey_greenstein_phase_eval_unit.sv
// henyey_greenstein_phase_eval_unit: top level of the phase function pipeline
// depends on hgp_pkg, hgp_isqrt and hgp_div
//
// usage
//   an item (cos_out, cos_in, azimuth_diff) is transferred on in_item_i at a
//   rising edge with start high and busy low; busy stays low, so one item can
//   be transferred every cycle
//   each result shows on result_o for one cycle with valid_o high, in
//   start order; the receiver cannot stall, and nothing in the pipeline
//   waits on it
//   throughput is one item per cycle; latency is set by the two 32-stage
//   square root pipelines and the 32-stage divider
//   asymmetry g is written with cfg_we_i / cfg_wdata_i while no item is in
//   flight; it resets to 0
//   reset clears all stage valid bits, so no result appears after reset
//   until a new item is started
module henyey_greenstein_phase_eval_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  hgp_pkg::hgp_in_t       in_item_i,
  input  logic                   cfg_we_i,
  input  logic signed [15:0]     cfg_wdata_i,
  output logic                   valid_o,
  output hgp_pkg::hgp_out_t      result_o
);

  localparam int NS = hgp_pkg::SQRT_STAGES;
  localparam int CB = hgp_pkg::COS_TABLE_BITS;

  typedef struct packed {
    logic signed [31:0] coci;
    logic [30:0]        cmag;
    logic               neg;
  } hgp_dl1_t;

  logic signed [15:0] cfg_q;
  logic [30:0]        g2_q;
  logic [59:0]        numprod_q;
  logic               in_xfer;

  assign busy    = 1'b0;
  assign in_xfer = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // numerator terms only follow the register
  logic signed [31:0] g2_full;
  logic [30:0]        numer;
  assign g2_full = 32'(cfg_q) * 32'(cfg_q);
  assign numer   = 31'(31'h40000000 - g2_q);

  always_ff @(posedge clk_i) begin
    g2_q      <= 31'(g2_full);
    numprod_q <= 60'(numer) * 60'(hgp_pkg::INV4PI_Q32);
  end

  // stage a: products and azimuth cosine
  logic signed [31:0] coci_a_d, co2, ci2;
  logic [16:0]        phi_rnd;
  logic [CB-1:0]      k;
  logic [CB-3:0]      tix;
  logic [30:0]        cr, sr;

  assign coci_a_d = 32'(in_item_i.cos_out) * 32'(in_item_i.cos_in);
  assign co2      = 32'(in_item_i.cos_out) * 32'(in_item_i.cos_out);
  assign ci2      = 32'(in_item_i.cos_in) * 32'(in_item_i.cos_in);
  assign phi_rnd  = {1'b0, in_item_i.azimuth_diff} + (17'd1 << (hgp_pkg::AZ_SHIFT - 1));
  assign k        = phi_rnd[hgp_pkg::AZ_SHIFT +: CB];
  assign tix      = k[CB-3:0];
  assign cr       = hgp_pkg::COS_TAB[tix];
  assign sr       = hgp_pkg::SIN_TAB[tix];

  logic               vld_a_q;
  logic signed [31:0] coci_a_q;
  logic [30:0]        so_a_q, si_a_q, cmag_a_q;
  logic               neg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q <= 1'b0;
    end else begin
      vld_a_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    coci_a_q <= coci_a_d;
    so_a_q   <= 31'(32'sh40000000 - co2);
    si_a_q   <= 31'(32'sh40000000 - ci2);
    // odd quadrants use the sine, middle two are negative
    cmag_a_q <= k[CB-2] ? sr : cr;
    neg_a_q  <= k[CB-1] ^ k[CB-2];
  end

  // stage b: sine product
  logic       vld_b_q;
  logic [61:0] prod_b_q;
  hgp_dl1_t   dl1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_b_q <= 1'b0;
    end else begin
      vld_b_q <= vld_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_b_q <= 62'(so_a_q) * 62'(si_a_q);
    dl1_b_q  <= '{coci: coci_a_q, cmag: cmag_a_q, neg: neg_a_q};
  end

  logic        sq1_vld;
  logic [31:0] sq1_root;

  hgp_isqrt u_sqrt_sin (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_b_q),
    .radicand_i ({2'b0, prod_b_q}),
    .valid_o    (sq1_vld),
    .root_o     (sq1_root)
  );

  hgp_dl1_t dl1_q [NS];
  always_ff @(posedge clk_i) begin
    dl1_q[0] <= dl1_b_q;
    for (int i = 1; i < NS; i++) begin
      dl1_q[i] <= dl1_q[i-1];
    end
  end

  // stage c: cross term magnitude
  logic               vld_c_q;
  logic [30:0]        cross_c_q;
  logic signed [31:0] coci_c_q;
  logic               neg_c_q;
  logic [61:0]        cross_prod;

  assign cross_prod = 62'(dl1_q[NS-1].cmag) * 62'(sq1_root[30:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_c_q <= 1'b0;
    end else begin
      vld_c_q <= sq1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cross_c_q <= cross_prod[60:30];
    coci_c_q  <= dl1_q[NS-1].coci;
    neg_c_q   <= dl1_q[NS-1].neg;
  end

  // stage d: scattering cosine, clamped to [-1, 1]
  logic signed [32:0] cross_s, ct_sum;
  logic signed [31:0] ct_d_d;
  logic               vld_d_q;
  logic signed [31:0] ct_d_q;

  assign cross_s = neg_c_q ? -$signed({2'b0, cross_c_q}) : $signed({2'b0, cross_c_q});
  assign ct_sum  = 33'(coci_c_q) + cross_s;

  always_comb begin
    if (ct_sum > 33'sh040000000) begin
      ct_d_d = 32'sh40000000;
    end else if (ct_sum < -33'sh040000000) begin
      ct_d_d = -32'sh40000000;
    end else begin
      ct_d_d = 32'(ct_sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_d_q <= 1'b0;
    end else begin
      vld_d_q <= vld_c_q;
    end
  end

  always_ff @(posedge clk_i) begin
    ct_d_q <= ct_d_d;
  end

  // stage e: g * cos
  logic               vld_e_q;
  logic signed [46:0] gct_e_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_e_q <= 1'b0;
    end else begin
      vld_e_q <= vld_d_q;
    end
  end

  always_ff @(posedge clk_i) begin
    gct_e_q <= 47'(cfg_q) * 47'(ct_d_q);
  end

  // stage f: t = 1 + g^2 - 2gc, truncated toward zero, at least one lsb
  logic [46:0]        gabs;
  logic [32:0]        gsh;
  logic signed [33:0] gterm, tt;
  logic [32:0]        t_f_d;
  logic               vld_f_q;
  logic [32:0]        t_f_q;

  assign gabs  = gct_e_q[46] ? 47'(-gct_e_q) : 47'(gct_e_q);
  assign gsh   = gabs[46:14];
  assign gterm = gct_e_q[46] ? -$signed({1'b0, gsh}) : $signed({1'b0, gsh});
  assign tt    = 34'sh040000000 + $signed({3'b0, g2_q}) - gterm;

  always_comb begin
    if (tt < 34'sd1) begin
      t_f_d = 33'd1;
    end else begin
      t_f_d = 33'(tt);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_f_q <= 1'b0;
    end else begin
      vld_f_q <= vld_e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t_f_q <= t_f_d;
  end

  logic        sq2_vld;
  logic [31:0] sq2_root;

  hgp_isqrt u_sqrt_t (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_f_q),
    .radicand_i (64'(t_f_q) << 30),
    .valid_o    (sq2_vld),
    .root_o     (sq2_root)
  );

  logic [32:0] dl2_q [NS];
  always_ff @(posedge clk_i) begin
    dl2_q[0] <= t_f_q;
    for (int i = 1; i < NS; i++) begin
      dl2_q[i] <= dl2_q[i-1];
    end
  end

  // stage g: t^1.5 in q42
  logic [64:0] t15_prod;
  logic        vld_g_q;
  logic [45:0] t15_g_q;

  assign t15_prod = 65'(dl2_q[NS-1]) * 65'(sq2_root);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_g_q <= 1'b0;
    end else begin
      vld_g_q <= sq2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    t15_g_q <= t15_prod[63:18];
  end

  // stage h: rounded dividend
  logic        vld_h_q;
  logic [60:0] dvd_h_q;
  logic [45:0] dvs_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_h_q <= 1'b0;
    end else begin
      vld_h_q <= vld_g_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_h_q <= 61'(numprod_q) + 61'(t15_g_q >> 1);
    dvs_h_q <= t15_g_q;
  end

  logic        div_vld;
  logic [31:0] div_quot;
  logic        div_sat;

  hgp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vld_h_q),
    .dividend_i (dvd_h_q),
    .divisor_i  (dvs_h_q),
    .valid_o    (div_vld),
    .quot_o     (div_quot),
    .sat_o      (div_sat)
  );

  // output register; zero numerator wins over overflow
  logic              vld_o_q;
  hgp_pkg::hgp_out_t res_d, res_q;

  always_comb begin
    if (cfg_q == hgp_pkg::G_MINUS_ONE) begin
      res_d = '{density: 32'd0, saturated: 1'b0};
    end else if (div_sat) begin
      res_d = '{density: 32'hFFFFFFFF, saturated: 1'b1};
    end else begin
      res_d = '{density: div_quot, saturated: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_o_q <= 1'b0;
    end else begin
      vld_o_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign valid_o  = vld_o_q;
  assign result_o = res_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##(hgp_pkg::LATENCY) valid_o)
    else $error("result strobe not at fixed latency after start transfer");

  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.saturated) |-> (result_o.density == 32'hFFFFFFFF))
    else $error("saturated result without full-scale density");

  a_ct_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_d_q |-> ((ct_d_q <= 32'sh40000000) && (ct_d_q >= -32'sh40000000)))
    else $error("scattering cosine outside unit range");

  a_t_positive : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_f_q |-> (t_f_q != 33'd0))
    else $error("t term reached zero");

endmodule
